// ----- sv/pvd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared constants, types and arithmetic helpers for the polynomial
// value/derivative core (Q8.8 inputs, Q16.16 accumulator).
// ----------------------------------------------------------------------------
package pvd_pkg;

	localparam int unsigned MAX_DEGREE_DEF = 6;
	localparam int unsigned COEF_W         = 16;
	localparam int unsigned ACC_W          = 32;
	localparam int unsigned PROD_W         = ACC_W + COEF_W;
	localparam int unsigned IDX_W          = 3;
	localparam int unsigned DEG_W          = 3;

	localparam logic [IDX_W-1:0] REG_DEGREE = 3'd0;
	localparam logic [IDX_W-1:0] REG_COEF0  = 3'd1;

	localparam logic [ACC_W-1:0] ACC_MAX = 32'h7fff_ffff;
	localparam logic [ACC_W-1:0] ACC_MIN = 32'h8000_0000;

	// classified work item between front and back
	typedef struct packed {
		logic [COEF_W-1:0] point;
		logic              deriv;
		logic [DEG_W-1:0]  top;   // highest live term index
		logic              none;  // all terms zero
	} pvd_item_t;

	typedef struct packed {
		logic [ACC_W-1:0] value;
		logic             saturated;
	} pvd_res_t;

	// Horner term k widened to Q16.16; mult is k+1
	function automatic logic [ACC_W-1:0] term_q16(
		input logic [COEF_W-1:0] c_k,
		input logic [COEF_W-1:0] c_k1,
		input logic [2:0]        mult,
		input logic              live,
		input logic              deriv
	);
		logic signed [19:0] d;
		if (deriv) begin
			d = $signed({{4{c_k1[COEF_W-1]}}, c_k1}) * $signed({17'b0, mult});
		end else begin
			d = $signed({{4{c_k[COEF_W-1]}}, c_k});
		end
		return live ? {{4{d[19]}}, d, 8'b0} : '0;
	endfunction

	// acc*x rounded (half up), saturated, plus term, saturated
	function automatic pvd_res_t horner_step(
		input logic [PROD_W-1:0] prod,
		input logic [ACC_W-1:0]  t,
		input logic              sat_in
	);
		logic [PROD_W-1:0] rnd;
		logic [39:0]       r;
		logic              sat1;
		logic              sat2;
		logic [ACC_W-1:0]  rs;
		logic [ACC_W:0]    sum;
		pvd_res_t          res;
		rnd  = prod + PROD_W'(128);
		r    = rnd[PROD_W-1:8];
		sat1 = !((&r[39:31]) || !(|r[39:31]));
		rs   = sat1 ? (r[39] ? ACC_MIN : ACC_MAX) : r[ACC_W-1:0];
		sum  = {rs[ACC_W-1], rs} + {t[ACC_W-1], t};
		sat2 = sum[ACC_W] != sum[ACC_W-1];
		res.value     = sat2 ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
		res.saturated = sat_in | sat1 | sat2;
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- sv/polynomial_value_and_derivative_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// polynomial_value_and_derivative_core
// Evaluates p(x) or p'(x) by Horner's rule in Q16.16, saturating.
//
// Input queue: push/full, beat = {func, point}. Result queue: empty/pop,
// beat = {value, saturated}, oldest result shown while empty is low.
// Config: wr_en/wr_idx/wr_data; index 0 degree, 1..7 coef_0..coef_6.
// Write config only while the core is drained.
// Throughput: one beat per cycle while the receiver pops, set by the Horner
// pipeline which has a multiply stage and a round/add stage per degree step.
// A beat passes the input register, work queue, pipeline and result queue.
// A stalled receiver fills the result queue; the issue credit count then
// stops the work queue, the input register backs up and full rises.
// Reset empties the queues and zeroes the valids, credit count and config.
// ----------------------------------------------------------------------------
module polynomial_value_and_derivative_core import pvd_pkg::*; #(
	parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output      logic              full,
	input  wire logic              func,
	input  wire logic [COEF_W-1:0] point,
	output      logic              empty,
	input  wire logic              pop,
	output      logic [ACC_W-1:0]  value,
	output      logic              saturated,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_idx,
	input  wire logic [COEF_W-1:0] wr_data
);
	localparam int unsigned PIPE_LAT  = 2 * MAX_DEGREE + 1;
	localparam int unsigned OUT_DEPTH = PIPE_LAT + 2;
	localparam int unsigned CRD_W     = $clog2(OUT_DEPTH + 1);

	logic [DEG_W-1:0]  degree_q;
	logic [COEF_W-1:0] coef_q [MAX_DEGREE+1];

	logic              mid_push;
	logic              mid_full;
	logic              mid_empty;
	pvd_item_t         mid_in;
	pvd_item_t         mid_out;
	logic              issue;
	logic [CRD_W-1:0]  crd_q;
	logic              out_take;
	logic              out_vld;
	logic              out_full;
	pvd_res_t          out_res;
	pvd_res_t          head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
		end else if (wr_en && wr_idx == REG_DEGREE) begin
			degree_q <= wr_data[DEG_W-1:0];
		end
	end

	for (genvar i = 0; i <= MAX_DEGREE; i++) begin : g_coef
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coef_q[i] <= '0;
			end else if (wr_en && wr_idx == IDX_W'(REG_COEF0 + i)) begin
				coef_q[i] <= wr_data;
			end
		end
	end

	pvd_front #(.MAX_DEG(MAX_DEGREE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.func     (func),
		.point    (point),
		.degree   (degree_q),
		.full     (full),
		.mid_push (mid_push),
		.mid_item (mid_in),
		.mid_full (mid_full)
	);

	pvd_fifo #(.WIDTH($bits(pvd_item_t)), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.full   (mid_full),
		.pop    (issue),
		.rdata  (mid_out),
		.empty  (mid_empty)
	);

	assign issue    = !mid_empty && (crd_q < CRD_W'(OUT_DEPTH));
	assign out_take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crd_q <= '0;
		end else begin
			case ({issue, out_take})
				2'b10:   crd_q <= crd_q + 1'b1;
				2'b01:   crd_q <= crd_q - 1'b1;
				default: crd_q <= crd_q;
			endcase
		end
	end

	pvd_back #(.MAX_DEG(MAX_DEGREE)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (issue),
		.in_item (mid_out),
		.coef    (coef_q),
		.out_vld (out_vld),
		.out_res (out_res)
	);

	pvd_fifo #(.WIDTH($bits(pvd_res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_vld),
		.wdata  (out_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	assign value     = head.value;
	assign saturated = head.saturated;

`ifndef SYNTHESIS
	a_crd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		crd_q <= CRD_W'(OUT_DEPTH))
		else $error("issue credit count above result queue depth");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_vld && out_full))
		else $error("result beat written into a full result queue");

	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(mid_push && mid_full))
		else $error("work item pushed into a full work queue");

	a_pipe_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> $past(issue, PIPE_LAT))
		else $error("pipeline result without matching issue");
`endif

endmodule
`default_nettype wire

// ----- sv/pvd_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pvd_fifo
// Small synchronous queue with push/full and pop/empty; head shown on rdata.
// ----------------------------------------------------------------------------
module pvd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output      logic             full,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] rdata,
	output      logic             empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/pvd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pvd_front
// Input stage: takes a beat, clamps the degree, resolves value/derivative
// and hands the classified item to the work queue.
// ----------------------------------------------------------------------------
module pvd_front import pvd_pkg::*; #(
	parameter int unsigned MAX_DEG = MAX_DEGREE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic              func,
	input  wire logic [COEF_W-1:0] point,
	input  wire logic [DEG_W-1:0]  degree,
	output      logic              full,
	output      logic              mid_push,
	output      pvd_item_t         mid_item,
	input  wire logic              mid_full
);
	logic             valid_s1;
	pvd_item_t        item_s1;
	logic             accept;
	logic [DEG_W-1:0] n_eff;
	pvd_item_t        item_in;

	assign n_eff = (degree > DEG_W'(MAX_DEG)) ? DEG_W'(MAX_DEG) : degree;

	always_comb begin
		item_in.point = point;
		item_in.deriv = func;
		item_in.none  = func && (n_eff == '0);
		item_in.top   = func ? n_eff - 1'b1 : n_eff;
	end

	assign full     = valid_s1 && mid_full;
	assign accept   = push && !full;
	assign mid_push = valid_s1 && !mid_full;
	assign mid_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (mid_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

endmodule
`default_nettype wire

// ----- sv/pvd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pvd_back
// Horner pipeline: one multiply stage and one round/add stage per degree.
// Terms above the live index are zero, so every item runs the full depth.
// ----------------------------------------------------------------------------
module pvd_back import pvd_pkg::*; #(
	parameter int unsigned MAX_DEG = MAX_DEGREE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire pvd_item_t         in_item,
	input  wire logic [COEF_W-1:0] coef [MAX_DEG+1],
	output      logic              out_vld,
	output      pvd_res_t          out_res
);
	logic              vld_a  [1:MAX_DEG];
	pvd_item_t         item_a [1:MAX_DEG];
	logic [PROD_W-1:0] prod_a [1:MAX_DEG];
	logic              sat_a  [1:MAX_DEG];
	logic              vld_b  [0:MAX_DEG];
	pvd_item_t         item_b [0:MAX_DEG];
	logic [ACC_W-1:0]  acc_b  [0:MAX_DEG];
	logic              sat_b  [0:MAX_DEG];
	logic [ACC_W-1:0]  term_top;

	assign term_top = term_q16(coef[MAX_DEG], '0, 3'(MAX_DEG + 1),
		!in_item.none && (DEG_W'(MAX_DEG) <= in_item.top), in_item.deriv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b[0] <= 1'b0;
		end else begin
			vld_b[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		item_b[0] <= in_item;
		acc_b[0]  <= term_top;
		sat_b[0]  <= 1'b0;
	end

	for (genvar j = 1; j <= MAX_DEG; j++) begin : g_step
		localparam int unsigned K = MAX_DEG - j;
		logic [ACC_W-1:0]  t;
		pvd_res_t          nxt;
		logic [PROD_W-1:0] mul_acc;
		logic [PROD_W-1:0] mul_pt;

		// both operands sign-extended to the full product width
		assign mul_acc = {{COEF_W{acc_b[j-1][ACC_W-1]}}, acc_b[j-1]};
		assign mul_pt  = {{ACC_W{item_b[j-1].point[COEF_W-1]}}, item_b[j-1].point};

		always_comb begin
			t = term_q16(coef[K], coef[K+1], 3'(K + 1),
				!item_a[j].none && (DEG_W'(K) <= item_a[j].top), item_a[j].deriv);
			nxt = horner_step(prod_a[j], t, sat_a[j]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a[j] <= 1'b0;
				vld_b[j] <= 1'b0;
			end else begin
				vld_a[j] <= vld_b[j-1];
				vld_b[j] <= vld_a[j];
			end
		end

		always_ff @(posedge clk) begin
			item_a[j] <= item_b[j-1];
			prod_a[j] <= $signed(mul_acc) * $signed(mul_pt);
			sat_a[j]  <= sat_b[j-1];
			item_b[j] <= item_a[j];
			acc_b[j]  <= nxt.value;
			sat_b[j]  <= nxt.saturated;
		end
	end

	assign out_vld           = vld_b[MAX_DEG];
	assign out_res.value     = acc_b[MAX_DEG];
	assign out_res.saturated = sat_b[MAX_DEG];

endmodule
`default_nettype wire
